// ----- hw/rtl/stack_expression_evaluator_macros.svh -----
// assertion macros for the stack evaluator checker
`ifndef STACK_EXPRESSION_EVALUATOR_MACROS_SVH
`define STACK_EXPRESSION_EVALUATOR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SXE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stack evaluator check failed");

// next-cycle implication
`define SXE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stack evaluator check failed");

`endif

// ----- hw/rtl/sxe_pkg.sv -----
// constants shared by the stack expression evaluator files
package sxe_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int ENTRIES_W   = 5;
  localparam int ENTRIES_MAX = 31;
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [DATA_W-1:0] BAD_OP_RESULT = '1;

endpackage

// ----- hw/rtl/sxe_ram.sv -----
// generic single write port, single read port ram with registered read
module sxe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/stack_expression_evaluator.sv -----
// stack expression evaluator top level: sequencer, shared alu/divider, stack ram
// a digit word is pushed, then the word ends; other words pop twice, order operands, compute, push
// and end; a divide adds its divider steps and a sign step; a last word adds one stack read,
// then its result goes to the output register once that is free; one word at a time, set by the
// 32 step restoring divider and stack ram port; reset (async, active low) empties the stack,
// clears flags, eval_order back to postfix; the stack ram is not cleared: only entries below the count are read
module stack_expression_evaluator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 symbol_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [sxe_pkg::DATA_W-1:0]  value_o,
  output logic [sxe_pkg::ENTRIES_W-1:0]      entries_left_o,
  output logic                       underflow_seen_o,
  output logic                       overflow_seen_o,
  output logic                       div_zero_seen_o
);

  import sxe_pkg::*;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,   // waiting for a word
    ST_PUSH,   // write res_q on top of stack
    ST_FIN,    // end of word, start bottom read on last
    ST_POP1,   // pop first operand
    ST_POP2,   // capture first, pop second
    ST_OPS,    // capture second, order operands
    ST_ALU,    // add, sub, mul, bad-op result, or divider setup
    ST_DIV,    // one restoring divide step per cycle
    ST_DSIGN,  // apply quotient sign
    ST_RDB     // bottom entry in hand, hand result to output register
  } state_e;

  state_e state_q;

  // config
  logic eval_order_q;

  // latched word
  logic [7:0] sym_q;
  logic       last_q;

  // stack bookkeeping and sticky flags
  logic [CNT_W-1:0] count_q;
  logic             under_q;
  logic             over_q;
  logic             divz_q;

  // operand path
  logic              hit_q;    // last pop really read the ram
  logic [DATA_W-1:0] first_q;
  logic [DATA_W-1:0] opa_q;
  logic [DATA_W-1:0] opb_q;
  logic [DATA_W-1:0] res_q;

  // divider registers
  logic [DATA_W-1:0]    rem_q;
  logic [DATA_W-1:0]    quo_q;
  logic [DATA_W-1:0]    dvs_q;
  logic                 neg_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  // output register
  logic              out_valid_q;
  logic [DATA_W-1:0] value_q;
  logic [ENTRIES_W-1:0] entries_q;
  logic              under_out_q;
  logic              over_out_q;
  logic              divz_out_q;

  // ram hookup
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // combinational helpers
  logic              stack_empty;
  logic              stack_full;
  logic              in_accept;
  logic              out_free;
  logic              out_load;
  logic [DATA_W-1:0] pop_data;
  logic [DATA_W:0]   div_shift;
  logic [DATA_W:0]   div_diff;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic [ENTRIES_W-1:0] entries_sat;

  assign stack_empty = (count_q == '0);
  assign stack_full  = (count_q == CNT_W'(STACK_DEPTH));
  assign in_accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !(out_valid_q && out_stall_i);
  // result step hands its word to the output register
  assign out_load    = (state_q == ST_RDB) && out_free;

  // a pop that found the stack empty reads as zero
  assign pop_data = hit_q ? ram_rdata : '0;

  // one restoring step: shift in next dividend bit, try subtracting divisor
  assign div_shift = {rem_q, quo_q[DATA_W-1]};
  assign div_diff  = div_shift - {1'b0, dvs_q};

  assign mag_a = opa_q[DATA_W-1] ? (DATA_W'(0) - opa_q) : opa_q;
  assign mag_b = opb_q[DATA_W-1] ? (DATA_W'(0) - opb_q) : opb_q;

  assign entries_sat = (32'(count_q) > ENTRIES_MAX) ? ENTRIES_W'(ENTRIES_MAX)
                                                     : ENTRIES_W'(count_q);

  // stack ram port control
  always_comb begin
    ram_we    = (state_q == ST_PUSH) && !stack_full;
    ram_waddr = count_q[ADDR_W-1:0];
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(count_q - CNT_W'(1));
    unique case (state_q)
      ST_POP1, ST_POP2: ram_re = !stack_empty;
      ST_FIN: begin
        ram_re    = last_q;
        ram_raddr = '0;
      end
      default: ram_re = 1'b0;
    endcase
  end

  sxe_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_sxe_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (res_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer and all registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      eval_order_q <= 1'b0;
      count_q      <= '0;
      under_q      <= 1'b0;
      over_q       <= 1'b0;
      divz_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        eval_order_q <= cfg_wdata_i;
      end
      // output word loads from the result step, else leaves when taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            sym_q  <= symbol_i;
            last_q <= last_i;
            if (symbol_i >= CH_ZERO && symbol_i <= CH_NINE) begin
              // digit goes straight to the push step
              res_q   <= DATA_W'(8'(symbol_i - CH_ZERO));
              state_q <= ST_PUSH;
            end else begin
              state_q <= ST_POP1;
            end
          end
        end

        ST_POP1: begin
          hit_q <= !stack_empty;
          if (stack_empty) begin
            under_q <= 1'b1;
          end else begin
            count_q <= count_q - CNT_W'(1);
          end
          state_q <= ST_POP2;
        end

        ST_POP2: begin
          first_q <= pop_data;
          hit_q   <= !stack_empty;
          if (stack_empty) begin
            under_q <= 1'b1;
          end else begin
            count_q <= count_q - CNT_W'(1);
          end
          state_q <= ST_OPS;
        end

        ST_OPS: begin
          // postfix: first pop is the right operand, prefix swaps
          if (eval_order_q) begin
            opa_q <= first_q;
            opb_q <= pop_data;
          end else begin
            opa_q <= pop_data;
            opb_q <= first_q;
          end
          state_q <= ST_ALU;
        end

        ST_ALU: begin
          state_q <= ST_PUSH;
          unique case (sym_q)
            CH_PLUS:  res_q <= opa_q + opb_q;
            CH_MINUS: res_q <= opa_q - opb_q;
            CH_MUL:   res_q <= DATA_W'(opa_q * opb_q);
            CH_DIV: begin
              if (opb_q == '0) begin
                divz_q <= 1'b1;
                res_q  <= '0;
              end else begin
                rem_q     <= '0;
                quo_q     <= mag_a;
                dvs_q     <= mag_b;
                neg_q     <= opa_q[DATA_W-1] ^ opb_q[DATA_W-1];
                div_cnt_q <= DIV_CNT_W'(DATA_W - 1);
                state_q   <= ST_DIV;
              end
            end
            default:  res_q <= BAD_OP_RESULT;
          endcase
        end

        ST_DIV: begin
          if (!div_diff[DATA_W]) begin
            rem_q <= div_diff[DATA_W-1:0];
            quo_q <= {quo_q[DATA_W-2:0], 1'b1};
          end else begin
            rem_q <= div_shift[DATA_W-1:0];
            quo_q <= {quo_q[DATA_W-2:0], 1'b0};
          end
          div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
          if (div_cnt_q == '0) begin
            state_q <= ST_DSIGN;
          end
        end

        ST_DSIGN: begin
          // truncation toward zero, most negative / -1 wraps naturally
          res_q   <= neg_q ? (DATA_W'(0) - quo_q) : quo_q;
          state_q <= ST_PUSH;
        end

        ST_PUSH: begin
          if (stack_full) begin
            over_q <= 1'b1;
          end else begin
            count_q <= count_q + CNT_W'(1);
          end
          state_q <= ST_FIN;
        end

        ST_FIN: begin
          // bottom entry read was started above when last
          state_q <= last_q ? ST_RDB : ST_IDLE;
        end

        ST_RDB: begin
          // hold here until the output register is free
          if (out_load) begin
            value_q     <= stack_empty ? '0 : ram_rdata;
            entries_q   <= entries_sat;
            under_out_q <= under_q;
            over_out_q  <= over_q;
            divz_out_q  <= divz_q;
            count_q     <= '0;
            under_q     <= 1'b0;
            over_q      <= 1'b0;
            divz_q      <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign value_o          = signed'(value_q);
  assign entries_left_o   = entries_q;
  assign underflow_seen_o = under_out_q;
  assign overflow_seen_o  = over_out_q;
  assign div_zero_seen_o  = divz_out_q;

endmodule

// ----- hw/rtl/sxe_checker.sv -----
// port level checker for the stack expression evaluator, bound to the top level
`include "stack_expression_evaluator_macros.svh"

module sxe_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [sxe_pkg::DATA_W-1:0] value_o,
  input logic [sxe_pkg::ENTRIES_W-1:0]     entries_left_o
);

  import sxe_pkg::*;

  // entry count never exceeds the stack depth
  `SXE_ASSERT_NOW(a_entries_range, out_valid_o, 32'(entries_left_o) <= STACK_DEPTH)

  // an empty stack reports zero
  `SXE_ASSERT_NOW(a_empty_value, out_valid_o && entries_left_o == '0, value_o == '0)

  // busy right after an accept
  `SXE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // stalled result word holds
  `SXE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(value_o))

endmodule

bind stack_expression_evaluator sxe_checker u_sxe_checker (.*);

// ----- tb/tb_top.sv -----
// self-checking testbench for the stack expression evaluator with random idling on both sides
module tb_top;
  import sxe_pkg::*;

  localparam int LIMIT_CYCLES  = 600000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int RANDOM_WORDS  = 1080;
  localparam int RANDOM_PHASES = 6;

  localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;

  // one character word as the feeder presents it
  typedef struct {
    logic [7:0] symbol;
    logic       last;
  } char_word_t;

  // one predicted expression result
  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [ENTRIES_W-1:0]     entries;
    logic                     under;
    logic                     over;
    logic                     divz;
  } expr_result_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_we_i    = 1'b0;
  logic                        cfg_wdata_i = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  logic [7:0]                  symbol_i    = '0;
  logic                        last_i      = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [DATA_W-1:0]    value_o;
  logic [ENTRIES_W-1:0]        entries_left_o;
  logic                        underflow_seen_o;
  logic                        overflow_seen_o;
  logic                        div_zero_seen_o;

  stack_expression_evaluator DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .symbol_i         (symbol_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .value_o          (value_o),
    .entries_left_o   (entries_left_o),
    .underflow_seen_o (underflow_seen_o),
    .overflow_seen_o  (overflow_seen_o),
    .div_zero_seen_o  (div_zero_seen_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // evaluator model: its own stack, count, sticky flags and operand order
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] stk_mem [STACK_DEPTH];
  int unsigned              stk_cnt     = 0;
  logic                     flag_under  = 1'b0;
  logic                     flag_over   = 1'b0;
  logic                     flag_divz   = 1'b0;
  logic                     prefix_mode = 1'b0;

  expr_result_t expr_results_q[$];   // predicted results, oldest first
  char_word_t   word_q[$];           // words waiting for the driver
  logic [7:0]   expr_buf[$];         // expression under construction
  int unsigned  words_built = 0;
  int unsigned  err_cnt     = 0;
  int unsigned  cycle_cnt   = 0;
  int unsigned  tx_gap      = 0;
  int unsigned  rx_gap      = 0;
  logic         no_idle     = 1'b0;

  // a push onto a full stack is dropped
  function automatic void stk_push(logic signed [DATA_W-1:0] v);
    if (stk_cnt >= STACK_DEPTH) begin
      flag_over = 1'b1;
    end else begin
      stk_mem[stk_cnt] = v;
      stk_cnt++;
    end
  endfunction

  // a pop from an empty stack reads zero
  function automatic logic signed [DATA_W-1:0] stk_pop();
    if (stk_cnt == 0) begin
      flag_under = 1'b1;
      return '0;
    end
    stk_cnt--;
    return stk_mem[stk_cnt];
  endfunction

  function automatic logic signed [DATA_W-1:0] apply_op(logic [7:0] op,
                                                        logic signed [DATA_W-1:0] lhs,
                                                        logic signed [DATA_W-1:0] rhs);
    case (op)
      CH_PLUS:  return lhs + rhs;
      CH_MINUS: return lhs - rhs;
      CH_MUL:   return lhs * rhs;
      CH_DIV: begin
        // divide by zero pushes zero, most negative over minus one wraps
        if (rhs == 0) begin
          flag_divz = 1'b1;
          return '0;
        end
        if (lhs == MOST_NEG && rhs == -1) return MOST_NEG;
        return lhs / rhs;
      end
      default:  return BAD_OP_RESULT;
    endcase
  endfunction

  // advance the model by one accepted word, queue a result on the last one
  function automatic void eval_symbol(logic [7:0] sym, logic is_last);
    logic signed [DATA_W-1:0] first;
    logic signed [DATA_W-1:0] second;
    expr_result_t             r;
    if (sym >= CH_ZERO && sym <= CH_NINE) begin
      stk_push(DATA_W'(sym - CH_ZERO));
    end else begin
      first  = stk_pop();
      second = stk_pop();
      // postfix: first pop is the right operand, prefix: the left one
      if (prefix_mode) stk_push(apply_op(sym, first, second));
      else stk_push(apply_op(sym, second, first));
    end
    if (is_last) begin
      r.value   = (stk_cnt > 0) ? stk_mem[0] : '0;
      r.entries = (stk_cnt > ENTRIES_MAX) ? ENTRIES_W'(ENTRIES_MAX) : ENTRIES_W'(stk_cnt);
      r.under   = flag_under;
      r.over    = flag_over;
      r.divz    = flag_divz;
      expr_results_q.push_back(r);
      stk_cnt    = 0;
      flag_under = 1'b0;
      flag_over  = 1'b0;
      flag_divz  = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // expression builders
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] digit(int unsigned d);
    return CH_ZERO + 8'(d);
  endfunction

  // digits lean toward zero and nine so divide by zero comes up often
  function automatic logic [7:0] rand_digit();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return CH_ZERO;
    if (roll == 1) return CH_NINE;
    return digit($urandom_range(0, 9));
  endfunction

  // mostly the four operators, sometimes any other non-digit character
  function automatic logic [7:0] rand_op();
    logic [7:0] c;
    if ($urandom_range(0, 9) != 0) begin
      case ($urandom_range(0, 3))
        0:       return CH_PLUS;
        1:       return CH_MINUS;
        2:       return CH_MUL;
        default: return CH_DIV;
      endcase
    end
    do c = 8'($urandom_range(0, 255)); while (c >= CH_ZERO && c <= CH_NINE);
    return c;
  endfunction

  // move the built expression to the driver, last flag on its final character
  function automatic void flush_expr();
    char_word_t w;
    foreach (expr_buf[i]) begin
      w.symbol = expr_buf[i];
      w.last   = (i == expr_buf.size() - 1);
      word_q.push_back(w);
    end
    words_built += expr_buf.size();
    expr_buf.delete();
  endfunction

  // random well-formed expression, the same stack discipline serves both orders
  function automatic void build_well_formed();
    int unsigned n_ops;
    int unsigned pushed;
    int unsigned ops_done;
    int unsigned depth;
    n_ops    = $urandom_range(0, 7);
    pushed   = 0;
    ops_done = 0;
    depth    = 0;
    while (pushed < n_ops + 1 || ops_done < n_ops) begin
      if (depth < 2 || (pushed < n_ops + 1 && $urandom_range(0, 1) == 1)) begin
        expr_buf.push_back(rand_digit());
        pushed++;
        depth++;
      end else begin
        expr_buf.push_back(rand_op());
        ops_done++;
        depth--;
      end
    end
  endfunction

  // 8^10 * 2 wraps to the most negative value, then divide it by minus one
  function automatic void build_most_neg_div(logic prefix);
    if (prefix) expr_buf = {expr_buf, digit(1), digit(0), CH_MINUS};
    repeat (10) expr_buf.push_back(digit(8));
    expr_buf.push_back(digit(2));
    repeat (10) expr_buf.push_back(CH_MUL);
    if (!prefix) expr_buf = {expr_buf, digit(0), digit(1), CH_MINUS};
    expr_buf.push_back(CH_DIV);
  endfunction

  function automatic void build_phase(int unsigned n_words, logic with_most_neg, logic prefix);
    int unsigned start;
    int unsigned roll;
    start = words_built;
    if (with_most_neg) begin
      build_most_neg_div(prefix);
      flush_expr();
    end
    while (words_built - start < n_words) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        // can push past the top of the stack
        repeat ($urandom_range(14, 22)) expr_buf.push_back(rand_digit());
        repeat ($urandom_range(0, 3)) expr_buf.push_back(rand_op());
      end else if (roll < 16) begin
        // raw bytes, every bit of the symbol toggles
        repeat ($urandom_range(1, 12)) expr_buf.push_back(8'($urandom_range(0, 255)));
      end else if (roll < 26) begin
        // broken mix of digits and operators
        repeat ($urandom_range(2, 12)) begin
          if ($urandom_range(0, 1) == 1) expr_buf.push_back(rand_digit());
          else expr_buf.push_back(rand_op());
        end
      end else begin
        build_well_formed();
      end
      flush_expr();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued words, random idle bursts, holds while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    char_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      symbol_i   <= '0;
      last_i     <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) eval_symbol(symbol_i, last_i);
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (word_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
          // this cycle is the first of the burst
          tx_gap = $urandom_range(1, 6) - 1;
          in_valid_i <= 1'b0;
        end else begin
          w = word_q.pop_front();
          symbol_i   <= w.symbol;
          last_i     <= w.last;
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random stall bursts, every accepted result checked in order
  // ---------------------------------------------------------------------------
  function automatic void check_result();
    expr_result_t want;
    if (expr_results_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("result word with nothing expected: value %0d entries %0d flags %b%b%b",
                 value_o, entries_left_o, underflow_seen_o, overflow_seen_o, div_zero_seen_o);
      return;
    end
    want = expr_results_q.pop_front();
    if (value_o !== want.value || entries_left_o !== want.entries ||
        underflow_seen_o !== want.under || overflow_seen_o !== want.over ||
        div_zero_seen_o !== want.divz) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("mismatch: expected value %0d entries %0d uf/of/dz %b%b%b, got %0d %0d %b%b%b",
                 want.value, want.entries, want.under, want.over, want.divz,
                 value_o, entries_left_o, underflow_seen_o, overflow_seen_o, div_zero_seen_o);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result();
      if (rx_gap > 0) begin
        rx_gap--;
        out_stall_i <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(1, 6) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("stack_expression_evaluator test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing: register writes only when nothing is in flight
  // ---------------------------------------------------------------------------
  // sender holds off until all results are back, then lets a divide finish
  task automatic wait_idle();
    do @(negedge clk_i); while (word_q.size() != 0 || in_valid_i || expr_results_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_order(logic v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    prefix_mode = v;
  endtask

  initial begin
    logic mode;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, postfix order
    write_order(1'b0);
    @(negedge clk_i);
    expr_buf = '{digit(9)};                                       flush_expr();
    expr_buf = '{digit(0)};                                       flush_expr();
    expr_buf = '{digit(3), digit(9), CH_MINUS};                   flush_expr();
    expr_buf = '{digit(2), digit(6), CH_PLUS, digit(4), CH_MUL};  flush_expr();
    expr_buf = '{digit(8), digit(3), CH_DIV};                     flush_expr();
    // divide by zero
    expr_buf = '{digit(7), digit(0), CH_DIV};                     flush_expr();
    // character just above the digits is no operator
    expr_buf = '{digit(1), digit(2), CH_NINE + 8'd1};             flush_expr();
    // operators on an empty stack underflow
    expr_buf = '{8'h00};                                          flush_expr();
    expr_buf = '{8'hFF};                                          flush_expr();
    wait_idle();

    // directed, prefix order swaps the operands
    write_order(1'b1);
    @(negedge clk_i);
    expr_buf = '{digit(3), digit(9), CH_MINUS};                   flush_expr();
    expr_buf = '{digit(2), digit(7), CH_DIV};                     flush_expr();
    wait_idle();

    // random phases, the last one without any idling
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < 2) mode = ph[0];
      else mode = 1'($urandom_range(0, 1));
      write_order(mode);
      @(negedge clk_i);
      if (ph == RANDOM_PHASES - 1) no_idle = 1'b1;
      build_phase(RANDOM_WORDS / RANDOM_PHASES, ph < 2, mode);
      wait_idle();
    end

    if (err_cnt == 0 && expr_results_q.size() == 0) begin
      $display("stack_expression_evaluator test passed");
    end else begin
      $display("stack_expression_evaluator test failed");
    end
    $finish;
  end

endmodule
